/* hdl/rdf_pkg.sv */
`default_nettype none

package rdf_pkg;

  localparam logic [22:0] MAX_PAYLOAD_RESET = 23'd4194304;
  localparam logic [31:0] SIZE_CEILING      = 32'd4194304;
  localparam logic [31:0] FNV_BASIS         = 32'd2166136261;
  localparam logic [7:0]  RAMP_START        = 8'h5A;
  localparam logic [7:0]  RAMP_STEP         = 8'd31;
  localparam logic [3:0]  KEY_STEP          = 4'd7;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
  localparam logic [2:0] ST_TOO_LARGE = 3'd2;
  localparam logic [2:0] ST_TRUNCATED = 3'd3;
  localparam logic [2:0] ST_MISMATCH  = 3'd4;

  localparam logic [7:0] MAGIC [8] = '{
    8'h91, 8'h4D, 8'hE7, 8'h2A, 8'h63, 8'hB8, 8'h05, 8'hCF
  };

  localparam logic [7:0] KEY [16] = '{
    8'h37, 8'hC2, 8'h5B, 8'hA1, 8'hE8, 8'h0D, 8'h74, 8'h96,
    8'h43, 8'hFA, 8'h28, 8'hBD, 8'h61, 8'h8C, 8'h15, 8'hD0
  };

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_file;
  } item_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] plain_byte;
    logic       done_res;
    logic [2:0] status;
  } result_t;

  // The FNV prime is 2^24 + 2^8 + 2^7 + 2^4 + 2^1 + 1, so the product is a sum of shifts.
  function automatic logic [31:0] fnv_mul(input logic [31:0] x);
    fnv_mul = (x << 24) + (x << 8) + (x << 7) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

`default_nettype wire

/* hdl/rdf_if.sv */
`default_nettype none

interface rdf_stream_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_file;

  modport source (output valid, output in_byte, output end_of_file, input ready);
  modport sink   (input valid, input in_byte, input end_of_file, output ready);
endinterface

interface rdf_result_if;
  logic       valid;
  logic       ready;
  logic       byte_valid;
  logic [7:0] plain_byte;
  logic       done_res;
  logic [2:0] status;

  modport source (output valid, output byte_valid, output plain_byte, output done_res,
                  output status, input ready);
  modport sink   (input valid, input byte_valid, input plain_byte, input done_res,
                  input status, output ready);
endinterface

`default_nettype wire

/* hdl/rdf_core.sv */
`default_nettype none

module rdf_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             fire,
  input  wire rdf_pkg::item_t   item,
  input  wire logic [22:0]      max_payload,
  output logic                  have,
  output rdf_pkg::result_t      res
);

  localparam logic [1:0] PH_HEADER   = 2'd0;
  localparam logic [1:0] PH_PAYLOAD  = 2'd1;
  localparam logic [1:0] PH_FINISHED = 2'd2;

  logic [1:0]  phase, phase_next;
  logic [3:0]  header_count, header_count_next;
  logic        magic_ok, magic_ok_next;
  logic [31:0] declared_size, declared_size_next;
  logic [31:0] expected_hash, expected_hash_next;
  logic [22:0] bytes_left, bytes_left_next;
  logic [3:0]  key_pos, key_pos_next;
  logic [7:0]  ramp, ramp_next;
  logic [31:0] hash, hash_next;

  logic [7:0]  plain;
  logic [31:0] hash_mix;
  logic [31:0] exp_full;

  always_comb begin
    phase_next         = phase;
    header_count_next  = header_count;
    magic_ok_next      = magic_ok;
    declared_size_next = declared_size;
    expected_hash_next = expected_hash;
    bytes_left_next    = bytes_left;
    key_pos_next       = key_pos;
    ramp_next          = ramp;
    hash_next          = hash;
    have               = 1'b0;
    res                = '0;

    plain    = item.in_byte ^ rdf_pkg::KEY[key_pos] ^ ramp;
    hash_mix = rdf_pkg::fnv_mul(hash ^ {24'd0, plain});
    exp_full = {item.in_byte, expected_hash[23:0]};

    unique case (phase)
      PH_HEADER: begin
        header_count_next = header_count + 4'd1;
        if (!header_count[3]) begin
          if (item.in_byte != rdf_pkg::MAGIC[header_count[2:0]]) begin
            magic_ok_next = 1'b0;
          end
        end else if (!header_count[2]) begin
          declared_size_next[{header_count[1:0], 3'b000} +: 8] = item.in_byte;
        end else begin
          expected_hash_next[{header_count[1:0], 3'b000} +: 8] = item.in_byte;
        end
        if (header_count == 4'd15) begin
          have         = 1'b1;
          res.done_res = 1'b1;
          phase_next   = PH_FINISHED;
          if (!magic_ok) begin
            res.status = rdf_pkg::ST_BAD_MAGIC;
          end else if (declared_size > {9'd0, max_payload} ||
                       declared_size > rdf_pkg::SIZE_CEILING) begin
            res.status = rdf_pkg::ST_TOO_LARGE;
          end else if (declared_size == 32'd0) begin
            res.status = (hash == exp_full) ? rdf_pkg::ST_OK : rdf_pkg::ST_MISMATCH;
          end else begin
            have            = 1'b0;
            res.done_res    = 1'b0;
            phase_next      = PH_PAYLOAD;
            bytes_left_next = declared_size[22:0];
            key_pos_next    = declared_size[3:0];
            ramp_next       = rdf_pkg::RAMP_START;
            hash_next       = rdf_pkg::FNV_BASIS;
          end
        end
      end
      PH_PAYLOAD: begin
        have           = 1'b1;
        res.byte_valid = 1'b1;
        res.plain_byte = plain;
        hash_next      = hash_mix;
        key_pos_next   = key_pos + rdf_pkg::KEY_STEP;
        ramp_next      = ramp + rdf_pkg::RAMP_STEP;
        if (bytes_left != 23'd0) begin
          bytes_left_next = bytes_left - 23'd1;
        end
        if (bytes_left <= 23'd1) begin
          res.done_res = 1'b1;
          res.status   = (hash_mix == expected_hash) ? rdf_pkg::ST_OK : rdf_pkg::ST_MISMATCH;
          phase_next   = PH_FINISHED;
        end
      end
      default: begin
      end
    endcase

    if (item.end_of_file) begin
      if (phase_next != PH_FINISHED) begin
        have         = 1'b1;
        res.done_res = 1'b1;
        res.status   = rdf_pkg::ST_TRUNCATED;
      end
      phase_next         = PH_HEADER;
      header_count_next  = 4'd0;
      magic_ok_next      = 1'b1;
      declared_size_next = 32'd0;
      expected_hash_next = 32'd0;
      bytes_left_next    = 23'd0;
      key_pos_next       = 4'd0;
      ramp_next          = rdf_pkg::RAMP_START;
      hash_next          = rdf_pkg::FNV_BASIS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      header_count  <= 4'd0;
      magic_ok      <= 1'b1;
      declared_size <= 32'd0;
      expected_hash <= 32'd0;
      bytes_left    <= 23'd0;
      key_pos       <= 4'd0;
      ramp          <= rdf_pkg::RAMP_START;
      hash          <= rdf_pkg::FNV_BASIS;
    end else if (fire) begin
      phase         <= phase_next;
      header_count  <= header_count_next;
      magic_ok      <= magic_ok_next;
      declared_size <= declared_size_next;
      expected_hash <= expected_hash_next;
      bytes_left    <= bytes_left_next;
      key_pos       <= key_pos_next;
      ramp          <= ramp_next;
      hash          <= hash_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/obfuscated_record_deframer_unit.sv */
// Channel   Role    Payload                                          Transfer
// stream    sink    in_byte[7:0], end_of_file                        valid & ready
// result    source  byte_valid, plain_byte[7:0], done_res, status    valid & ready
// wr_*      config  wr_data[22:0] = max_payload_bytes                wr_en
//
// One byte per cycle unless a result stalls; a result passes the input and result registers.
// The pace is set by the per-byte hash update between the input and result registers.
// Reset is synchronous and needs no clearing pass; the size limit returns to 4194304.
// A stalled result holds the result register, and the input register keeps taking bytes
// that produce no result; a byte that produces one waits until the result register frees.

`default_nettype none

module obfuscated_record_deframer_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  rdf_stream_if.sink       stream,
  rdf_result_if.source     result,
  input  wire logic        wr_en,
  input  wire logic [22:0] wr_data
);

  logic                 s1_valid;
  rdf_pkg::item_t       s1_item;
  logic                 s1_fire;
  logic                 out_free;
  logic [22:0]          max_payload;
  logic                 have;
  rdf_pkg::result_t     core_res;
  logic                 res_valid;
  rdf_pkg::result_t     res_q;

  assign out_free     = !res_valid || result.ready;
  assign s1_fire      = s1_valid && (!have || out_free);
  assign stream.ready = !s1_valid || s1_fire;

  rdf_core u_core (
    .clk         (clk),
    .rst         (rst),
    .fire        (s1_fire),
    .item        (s1_item),
    .max_payload (max_payload),
    .have        (have),
    .res         (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      res_valid   <= 1'b0;
      max_payload <= rdf_pkg::MAX_PAYLOAD_RESET;
    end else begin
      if (wr_en) begin
        max_payload <= wr_data;
      end
      if (stream.ready) begin
        s1_valid <= stream.valid;
      end
      if (s1_fire && have) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      s1_item <= '{in_byte: stream.in_byte, end_of_file: stream.end_of_file};
    end
    if (s1_fire && have) begin
      res_q <= core_res;
    end
  end

  assign result.valid      = res_valid;
  assign result.byte_valid = res_q.byte_valid;
  assign result.plain_byte = res_q.plain_byte;
  assign result.done_res   = res_q.done_res;
  assign result.status     = res_q.status;

  a_result_nonempty: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_q.byte_valid || res_q.done_res))
    else $error("result transfer carries neither a byte nor a verdict");

  a_fields_zeroed: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((res_q.byte_valid || res_q.plain_byte == 8'd0) &&
                   (res_q.done_res || res_q.status == rdf_pkg::ST_OK)))
    else $error("unused result field is not zero");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_q.status <= rdf_pkg::ST_MISMATCH))
    else $error("status code out of range");

  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !stream.ready |-> (s1_valid && have && res_valid && !result.ready))
    else $error("input stalled without a blocked result");

endmodule

`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 100ps

module testbench;

  localparam logic [31:0] FNV_PRIME = 32'd16777619;
  localparam int BYTES_PER_SETTING = 310;

  typedef enum logic [1:0] {PH_HEADER, PH_PAYLOAD, PH_FINISHED} rec_phase_t;

  typedef enum int {
    REC_GOOD, REC_BAD_SUM, REC_BAD_MAGIC, REC_TOO_BIG,
    REC_CUT_HEADER, REC_CUT_BODY, REC_EMPTY, REC_NOISE, REC_KINDS
  } rec_kind_t;

  logic        clk;
  logic        rst;
  logic        wr_en;
  logic [22:0] wr_data;

  rdf_stream_if in_ch ();
  rdf_result_if out_ch ();

  obfuscated_record_deframer_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .stream  (in_ch),
    .result  (out_ch),
    .wr_en   (wr_en),
    .wr_data (wr_data)
  );

  rec_phase_t  rec_phase;
  logic [3:0]  hdr_count;
  logic        magic_ok;
  logic [31:0] size_decl;
  logic [31:0] hash_decl;
  logic [31:0] hash_run;
  logic [22:0] bytes_left;
  logic [22:0] size_limit;
  logic [3:0]  key_idx;
  logic [7:0]  ramp;

  rdf_pkg::item_t   file_bytes [$];
  rdf_pkg::result_t predicted_out [$];
  logic [7:0]       rec_raw [$];
  logic [7:0]       body_plain [$];
  int               bytes_queued;
  int               bytes_taken;
  int               bad_count;
  int               send_gap;
  int               take_stall;
  logic             send_calm;
  logic             take_calm;

  initial begin : clock_gen
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void clear_record();
    rec_phase  = PH_HEADER;
    hdr_count  = 4'd0;
    magic_ok   = 1'b1;
    size_decl  = 32'd0;
    hash_decl  = 32'd0;
    bytes_left = 23'd0;
    key_idx    = 4'd0;
    ramp       = rdf_pkg::RAMP_START;
    hash_run   = rdf_pkg::FNV_BASIS;
  endfunction

  function automatic logic unmask_step(input logic [7:0] b, input logic eof,
                                       output rdf_pkg::result_t r);
    logic       have;
    logic [7:0] plain;
    int         n;
    have = 1'b0;
    r = '0;
    if (rec_phase == PH_HEADER) begin
      n = int'(hdr_count);
      if (n < 8) begin
        if (b != rdf_pkg::MAGIC[hdr_count[2:0]]) magic_ok = 1'b0;
      end else if (n < 12) begin
        size_decl[8 * (n - 8) +: 8] = b;
      end else begin
        hash_decl[8 * (n - 12) +: 8] = b;
      end
      hdr_count = hdr_count + 4'd1;
      if (n == 15) begin
        have = 1'b1;
        r.done_res = 1'b1;
        rec_phase = PH_FINISHED;
        if (!magic_ok) begin
          r.status = rdf_pkg::ST_BAD_MAGIC;
        end else if (size_decl > {9'd0, size_limit} || size_decl > rdf_pkg::SIZE_CEILING) begin
          r.status = rdf_pkg::ST_TOO_LARGE;
        end else if (size_decl == 32'd0) begin
          r.status = (hash_run == hash_decl) ? rdf_pkg::ST_OK : rdf_pkg::ST_MISMATCH;
        end else begin
          have = 1'b0;
          r.done_res = 1'b0;
          rec_phase = PH_PAYLOAD;
          bytes_left = size_decl[22:0];
          key_idx = size_decl[3:0];
          ramp = rdf_pkg::RAMP_START;
          hash_run = rdf_pkg::FNV_BASIS;
        end
      end
    end else if (rec_phase == PH_PAYLOAD) begin
      plain = b ^ rdf_pkg::KEY[key_idx] ^ ramp;
      hash_run = (hash_run ^ {24'd0, plain}) * FNV_PRIME;
      key_idx = key_idx + rdf_pkg::KEY_STEP;
      ramp = ramp + rdf_pkg::RAMP_STEP;
      have = 1'b1;
      r.byte_valid = 1'b1;
      r.plain_byte = plain;
      if (bytes_left > 0) bytes_left = bytes_left - 23'd1;
      if (bytes_left == 0) begin
        r.done_res = 1'b1;
        r.status = (hash_run == hash_decl) ? rdf_pkg::ST_OK : rdf_pkg::ST_MISMATCH;
        rec_phase = PH_FINISHED;
      end
    end
    if (eof) begin
      if (rec_phase != PH_FINISHED) begin
        have = 1'b1;
        r.done_res = 1'b1;
        r.status = rdf_pkg::ST_TRUNCATED;
      end
      clear_record();
    end
    return have;
  endfunction

  always @(posedge clk) begin : drive_bytes
    logic             busy;
    rdf_pkg::item_t   nxt;
    rdf_pkg::result_t r;
    busy = in_ch.valid;
    if (rst) begin
      busy = 1'b0;
      send_gap = 0;
      send_calm = 1'b0;
      bytes_taken = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (unmask_step(in_ch.in_byte, in_ch.end_of_file, r))
          predicted_out.insert(predicted_out.size(), r);
        bytes_taken++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (file_bytes.size() > 0) begin
          nxt = file_bytes.pop_front();
          in_ch.in_byte <= nxt.in_byte;
          in_ch.end_of_file <= nxt.end_of_file;
          busy = 1'b1;
          if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
          send_gap = send_calm ? 0 : $urandom_range(0, 7);
        end
      end
    end
    in_ch.valid <= busy;
  end

  always @(posedge clk) begin : watch_results
    rdf_pkg::result_t got;
    rdf_pkg::result_t want;
    logic             take;
    if (rst) begin
      take_stall = 0;
      take = 1'b0;
      take_calm = 1'b0;
      bad_count = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.byte_valid = out_ch.byte_valid;
        got.plain_byte = out_ch.plain_byte;
        got.done_res = out_ch.done_res;
        got.status = out_ch.status;
        if (predicted_out.size() == 0) begin
          bad_count++;
          if (bad_count <= 10)
            $display("%0t: extra result bv=%0b pb=%02h done=%0b st=%0d",
                     $realtime, got.byte_valid, got.plain_byte, got.done_res, got.status);
        end else begin
          want = predicted_out.pop_front();
          if (got.byte_valid !== want.byte_valid || got.plain_byte !== want.plain_byte ||
              got.done_res !== want.done_res || got.status !== want.status) begin
            bad_count++;
            if (bad_count <= 10)
              $display("%0t: expected %0b/%02h/%0b/%0d, actual %0b/%02h/%0b/%0d",
                       $realtime, want.byte_valid, want.plain_byte, want.done_res,
                       want.status, got.byte_valid, got.plain_byte, got.done_res,
                       got.status);
          end
        end
        if ($urandom_range(0, 39) == 0) take_calm = !take_calm;
        take_stall = take_calm ? 0 : $urandom_range(0, 7);
      end
      if (take_stall > 0) begin
        take = 1'b0;
        take_stall--;
      end else begin
        take = 1'b1;
      end
    end
    out_ch.ready <= take;
  end

  function automatic void add_header(input logic [31:0] size, input logic [31:0] sum);
    for (int i = 0; i < 8; i++) rec_raw.insert(rec_raw.size(), rdf_pkg::MAGIC[i]);
    for (int i = 0; i < 4; i++) rec_raw.insert(rec_raw.size(), size[8 * i +: 8]);
    for (int i = 0; i < 4; i++) rec_raw.insert(rec_raw.size(), sum[8 * i +: 8]);
  endfunction

  function automatic logic [31:0] make_body(input logic [31:0] size);
    logic [31:0] h;
    logic [7:0]  p;
    h = rdf_pkg::FNV_BASIS;
    body_plain.delete();
    for (int i = 0; i < size; i++) begin
      p = 8'($urandom);
      body_plain.insert(body_plain.size(), p);
      h = (h ^ {24'd0, p}) * FNV_PRIME;
    end
    return h;
  endfunction

  function automatic void add_body(input logic [31:0] size, input int count);
    logic [3:0] k;
    logic [7:0] m;
    k = size[3:0];
    m = rdf_pkg::RAMP_START;
    for (int i = 0; i < count; i++) begin
      rec_raw.insert(rec_raw.size(), body_plain[i] ^ rdf_pkg::KEY[k] ^ m);
      k = k + rdf_pkg::KEY_STEP;
      m = m + rdf_pkg::RAMP_STEP;
    end
  endfunction

  // The file's last byte carries the end-of-file mark.
  function automatic void flush_record(input int trail);
    rdf_pkg::item_t it;
    for (int i = 0; i < trail; i++) rec_raw.insert(rec_raw.size(), 8'($urandom));
    foreach (rec_raw[i]) begin
      it.in_byte = rec_raw[i];
      it.end_of_file = (i == rec_raw.size() - 1);
      file_bytes.insert(file_bytes.size(), it);
    end
    bytes_queued += rec_raw.size();
    rec_raw.delete();
  endfunction

  function automatic int trail_len();
    return $urandom_range(0, 1) ? 0 : $urandom_range(1, 4);
  endfunction

  function automatic logic [31:0] fit_size();
    int cap;
    int lim;
    lim = int'({9'd0, size_limit});
    cap = (lim > 24) ? 24 : lim;
    if ($urandom_range(0, 9) == 0) cap = (lim > 300) ? 300 : lim;
    if (lim <= 300 && $urandom_range(0, 3) == 0) return 32'(lim);
    return (cap == 0) ? 32'd0 : 32'($urandom_range(1, cap));
  endfunction

  function automatic rec_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return REC_GOOD;
    if (r < 45) return REC_BAD_SUM;
    if (r < 55) return REC_BAD_MAGIC;
    if (r < 65) return REC_TOO_BIG;
    if (r < 73) return REC_CUT_HEADER;
    if (r < 85) return REC_CUT_BODY;
    if (r < 92) return REC_EMPTY;
    return REC_NOISE;
  endfunction

  function automatic void queue_record(input rec_kind_t kind);
    logic [31:0] size;
    logic [31:0] sum;
    int          cut;
    case (kind)
      REC_GOOD, REC_BAD_SUM: begin
        size = fit_size();
        sum = make_body(size);
        if (kind == REC_BAD_SUM) sum = sum ^ (32'd1 << $urandom_range(0, 31));
        add_header(size, sum);
        add_body(size, size);
        flush_record(trail_len());
      end
      REC_EMPTY: begin
        sum = $urandom_range(0, 1) ? rdf_pkg::FNV_BASIS : 32'($urandom);
        add_header(32'd0, sum);
        flush_record(trail_len());
      end
      REC_BAD_MAGIC: begin
        size = $urandom_range(0, 1) ? 32'($urandom) : fit_size();
        add_header(size, 32'($urandom));
        rec_raw[$urandom_range(0, 7)] ^= 8'($urandom_range(1, 255));
        if ($urandom_range(0, 3) == 0) rec_raw[$urandom_range(0, 7)] ^= 8'($urandom);
        flush_record(trail_len());
      end
      REC_TOO_BIG: begin
        case ($urandom_range(0, 2))
          0: size = {9'd0, size_limit} + 32'd1;
          1: size = rdf_pkg::SIZE_CEILING + 32'd1 + 32'($urandom_range(0, 255));
          default: size = 32'($urandom) | 32'h8000_0000;
        endcase
        add_header(size, 32'($urandom));
        flush_record(trail_len());
      end
      REC_CUT_HEADER, REC_CUT_BODY: begin
        size = fit_size();
        sum = make_body(size);
        add_header(size, sum);
        if (kind == REC_CUT_BODY && size > 0) begin
          add_body(size, $urandom_range(0, size - 1));
        end else begin
          cut = $urandom_range(1, 15);
          while (rec_raw.size() > cut) rec_raw.delete(rec_raw.size() - 1);
        end
        flush_record(0);
      end
      default: begin
        if ($urandom_range(0, 1)) add_header(32'($urandom), 32'($urandom));
        flush_record($urandom_range(1, 40));
      end
    endcase
  endfunction

  task automatic wait_idle();
    while (bytes_taken != bytes_queued || predicted_out.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin : run_stimulus
    logic [22:0] limits [6];
    int          target;
    limits = '{rdf_pkg::MAX_PAYLOAD_RESET, 23'd0, 23'd23, 23'd1, 23'd4194304, 23'd300};
    rst = 1'b1;
    wr_en = 1'b0;
    wr_data = 23'd0;
    bytes_queued = 0;
    size_limit = rdf_pkg::MAX_PAYLOAD_RESET;
    clear_record();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 6; ph++) begin
      // The limit only changes once every transfer of the previous setting has drained.
      if (ph > 0) begin
        wait_idle();
        wr_en <= 1'b1;
        wr_data <= limits[ph];
        @(posedge clk);
        wr_en <= 1'b0;
        size_limit = limits[ph];
      end
      if (ph == 0) begin
        rec_raw.insert(rec_raw.size(), 8'hFF);
        flush_record(0);
        add_header(32'd0, rdf_pkg::FNV_BASIS);
        flush_record(0);
        for (int k = 0; k < REC_KINDS; k++) queue_record(rec_kind_t'(k));
      end
      target = bytes_queued + BYTES_PER_SETTING;
      while (bytes_queued < target) queue_record(pick_kind());
    end
    wait_idle();
    if (bad_count == 0 && predicted_out.size() == 0) begin
      $display("obfuscated_record_deframer_unit: match");
    end else begin
      $display("obfuscated_record_deframer_unit: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("obfuscated_record_deframer_unit: mismatch");
    $finish;
  end

endmodule

/* obfuscated_record_deframer_unit.f */
hdl/rdf_pkg.sv
hdl/rdf_if.sv
hdl/rdf_core.sv
hdl/obfuscated_record_deframer_unit.sv
verif/testbench.sv
